### rtl/core/scalar_kalman_sample_filter_macros.svh
// shared assertion macros, clocked on clk and held off during rst
`ifndef SCALAR_KALMAN_SAMPLE_FILTER_MACROS_SVH
`define SCALAR_KALMAN_SAMPLE_FILTER_MACROS_SVH

// property that must hold at every edge
`define SKF_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// condition at one edge implies an expression at the next edge
`define SKF_CHECK_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

### rtl/core/skf_pkg.sv
package skf_pkg;

  localparam int SAMPLE_W        = 12;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_E          = 16;
  localparam int FRAC_P          = 24;
  localparam int COV_W           = 32;
  localparam int GAIN_W          = FRAC_P + 1;
  localparam int QN_W            = 24;
  localparam int RN_W            = 32;
  localparam int THR_W           = 12;
  localparam int BW_W            = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int MUL_A_W         = GAIN_W + 1;

  localparam logic [QN_W-1:0]   QN_RESET  = 24'd1678;
  localparam logic [RN_W-1:0]   RN_RESET  = 32'd167772160;
  localparam logic [THR_W-1:0]  THR_RESET = 12'd50;
  localparam logic [BW_W-1:0]   BW_RESET  = 16'd38142;
  localparam logic [COV_W-1:0]  COV_RESET = 32'd16777216;

  localparam logic [GAIN_W-1:0] ONE_P  = 25'h100_0000;
  localparam logic [FRAC_P-1:0] HALF_P = 24'h80_0000;
  localparam logic [FRAC_E-1:0] HALF_E = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCESS_NOISE = 2'd0,
    REG_MEAS_NOISE    = 2'd1,
    REG_JUMP_THR      = 2'd2,
    REG_BLEND_W       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                jump_seen;
  } out_item_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_LOAD      = 4'd1,
    OP_PREP      = 4'd2,
    OP_BLEND_MUL = 4'd3,
    OP_BLEND_ADD = 4'd4,
    OP_DENOM     = 4'd5,
    OP_DIV_START = 4'd6,
    OP_MAG       = 4'd7,
    OP_CORR_MUL  = 4'd8,
    OP_CORR_ADD  = 4'd9,
    OP_COV_MUL   = 4'd10,
    OP_COV_ADD   = 4'd11,
    OP_EMIT      = 4'd12
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NONE     = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NO_REQ   = 3'd2,
    C_NO_JUMP  = 3'd3,
    C_DIV_BUSY = 3'd4,
    C_OUT_BUSY = 3'd5
  } cond_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE      = 4'd0;
  localparam step_t STEP_PREP      = 4'd1;
  localparam step_t STEP_BLEND_MUL = 4'd2;
  localparam step_t STEP_BLEND_ADD = 4'd3;
  localparam step_t STEP_DENOM     = 4'd4;
  localparam step_t STEP_DIV_GO    = 4'd5;
  localparam step_t STEP_DIV_WAIT  = 4'd6;
  localparam step_t STEP_MAG       = 4'd7;
  localparam step_t STEP_CORR_MUL  = 4'd8;
  localparam step_t STEP_CORR_ADD  = 4'd9;
  localparam step_t STEP_COV_MUL   = 4'd10;
  localparam step_t STEP_COV_ADD   = 4'd11;
  localparam step_t STEP_EMIT      = 4'd12;
  localparam step_t STEP_RET       = 4'd13;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic idle;
  } ctrl_t;

  typedef struct packed {
    logic jump;
    logic div_busy;
    logic out_busy;
  } status_t;

  // control store: a taken condition loads target, otherwise the step advances
  function automatic uword_t skf_ucode(input step_t step);
    uword_t w;
    unique case (step)
      STEP_IDLE:      w = '{op: OP_LOAD,      cond: C_NO_REQ,   target: STEP_IDLE};
      STEP_PREP:      w = '{op: OP_PREP,      cond: C_NONE,     target: STEP_IDLE};
      STEP_BLEND_MUL: w = '{op: OP_BLEND_MUL, cond: C_NO_JUMP,  target: STEP_DENOM};
      STEP_BLEND_ADD: w = '{op: OP_BLEND_ADD, cond: C_NONE,     target: STEP_IDLE};
      STEP_DENOM:     w = '{op: OP_DENOM,     cond: C_NONE,     target: STEP_IDLE};
      STEP_DIV_GO:    w = '{op: OP_DIV_START, cond: C_NONE,     target: STEP_IDLE};
      STEP_DIV_WAIT:  w = '{op: OP_NOP,       cond: C_DIV_BUSY, target: STEP_DIV_WAIT};
      STEP_MAG:       w = '{op: OP_MAG,       cond: C_NONE,     target: STEP_IDLE};
      STEP_CORR_MUL:  w = '{op: OP_CORR_MUL,  cond: C_NONE,     target: STEP_IDLE};
      STEP_CORR_ADD:  w = '{op: OP_CORR_ADD,  cond: C_NONE,     target: STEP_IDLE};
      STEP_COV_MUL:   w = '{op: OP_COV_MUL,   cond: C_NONE,     target: STEP_IDLE};
      STEP_COV_ADD:   w = '{op: OP_COV_ADD,   cond: C_NONE,     target: STEP_IDLE};
      STEP_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: STEP_EMIT};
      STEP_RET:       w = '{op: OP_NOP,       cond: C_ALWAYS,   target: STEP_IDLE};
      default:        w = '{op: OP_NOP,       cond: C_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/skf_stream_if.sv
interface skf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/skf_div.sv
// restoring divider, one quotient bit per cycle: floor(dividend * 2^FRAC_P / divisor)
module skf_div import skf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [COV_W-1:0]  dividend,
  input  logic [COV_W:0]    divisor,
  output logic              busy,
  output logic [GAIN_W-1:0] quotient
);

  localparam int REM_W = COV_W + 2;
  localparam int CNT_W = $clog2(GAIN_W);

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sub;
  logic [REM_W-1:0] rem_next;
  logic [CNT_W-1:0] cnt;
  logic             ge;

  assign ge       = rem >= {1'b0, divisor};
  assign rem_sub  = ge ? rem - {1'b0, divisor} : rem;
  assign rem_next = {rem_sub[REM_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      rem      <= {2'b00, dividend};
      quotient <= '0;
      cnt      <= CNT_W'(GAIN_W - 1);
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[GAIN_W-2:0], ge};
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/skf_seq.sv
`include "scalar_kalman_sample_filter_macros.svh"

module skf_seq import skf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output ctrl_t   ctrl
);

  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   take;
  logic   op_en;

  assign uw = skf_ucode(pc);

  always_comb begin
    unique case (uw.cond)
      C_NONE:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_REQ:   take = !in_valid;
      C_NO_JUMP:  take = !status.jump;
      C_DIV_BUSY: take = status.div_busy;
      C_OUT_BUSY: take = status.out_busy;
      default:    take = 1'b1;
    endcase
  end

  // load fires only on an accepted request, emit only into a free output slot
  always_comb begin
    priority case (uw.op)
      OP_LOAD: op_en = in_valid;
      OP_EMIT: op_en = !status.out_busy;
      default: op_en = 1'b1;
    endcase
  end

  assign pc_next   = take ? uw.target : pc + STEP_W'(1);
  assign ctrl.op   = op_en ? uw.op : OP_NOP;
  assign ctrl.idle = (pc == STEP_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  `SKF_CHECK_NEXT(a_leave_idle, ctrl.idle && in_valid, !ctrl.idle, "accepted request did not start the program")
  `SKF_CHECK(a_idle_div_quiet, !ctrl.idle || !status.div_busy, "divider busy while idle")
  `SKF_CHECK(a_gain_ready, (pc != STEP_MAG) || !status.div_busy, "gain read before divider finished")

endmodule

### rtl/core/skf_dp.sv
module skf_dp import skf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_t                 ctrl,
  input  in_item_t              item,
  input  logic                  out_ready,
  output logic                  out_valid,
  output out_item_t             out_item,
  output status_t               status
);

  localparam int EW      = SAMPLE_BITS + FRAC_E;
  localparam int MUL_B_W = (EW + 1 > COV_W + 1) ? EW + 1 : COV_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int CMP_W   = COV_W + 1;

  // configuration
  logic [QN_W-1:0]  q_noise;
  logic [RN_W-1:0]  r_noise;
  logic [THR_W-1:0] thr;
  logic [BW_W-1:0]  weight;

  // filter state and working registers
  logic [EW-1:0]            est;
  logic [COV_W-1:0]         cov;
  logic [SAMPLE_BITS-1:0]   s_r;
  logic                     jump_r;
  logic signed [EW:0]       diff_r;
  logic [COV_W-1:0]         pp_r;
  logic [EW-1:0]            pred_r;
  logic [COV_W:0]           denom_r;
  logic [GAIN_W-1:0]        gain_r;
  logic [EW-1:0]            mag_r;
  logic                     neg_r;
  logic signed [PROD_W-1:0] prod_r;

  logic [EW-1:0]             z;
  logic [EW-1:0]             distance;
  logic [COV_W:0]            pp_sum;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  blend_rnd;
  logic signed [EW+1:0]      pred_sum;
  logic signed [PROD_W-1:0]  corr_full;
  logic [EW:0]               corr;
  logic signed [EW+1:0]      est_sum;
  logic [EW-1:0]             est_clamped;
  logic signed [PROD_W-1:0]  cov_full;
  logic [EW:0]               est_rnd;
  logic [SAMPLE_BITS:0]      res;
  logic [SAMPLE_BITS-1:0]    res_sat;
  logic                      div_start;
  logic                      div_busy;
  logic [GAIN_W-1:0]         quotient;

  assign z        = {s_r, {FRAC_E{1'b0}}};
  assign distance = (est >= z) ? est - z : z - est;
  assign pp_sum   = CMP_W'(cov) + CMP_W'(q_noise);

  // shared multiplier operands
  always_comb begin
    unique case (ctrl.op)
      OP_BLEND_MUL: begin
        mul_a = $signed(MUL_A_W'(weight));
        mul_b = MUL_B_W'(diff_r);
      end
      OP_CORR_MUL: begin
        mul_a = $signed(MUL_A_W'(gain_r));
        mul_b = $signed(MUL_B_W'(mag_r));
      end
      OP_COV_MUL: begin
        mul_a = $signed(MUL_A_W'(ONE_P - gain_r));
        mul_b = $signed(MUL_B_W'(pp_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // est + floor((w * (z - est) + half) / 2^16) equals the two-sided blend
  assign blend_rnd = (prod_r + $signed(PROD_W'(HALF_E))) >>> FRAC_E;
  assign pred_sum  = $signed({2'b00, est}) + $signed({blend_rnd[EW], blend_rnd[EW:0]});

  // correction rounds half away from zero on the magnitude
  assign corr_full = prod_r + $signed(PROD_W'(HALF_P));
  assign corr      = corr_full[FRAC_P +: EW + 1];
  assign est_sum   = neg_r ? $signed({2'b00, pred_r}) - $signed({1'b0, corr})
                           : $signed({2'b00, pred_r}) + $signed({1'b0, corr});

  always_comb begin
    if (est_sum[EW+1]) begin
      est_clamped = '0;
    end else if (est_sum[EW]) begin
      est_clamped = '1;
    end else begin
      est_clamped = est_sum[EW-1:0];
    end
  end

  assign cov_full = prod_r + $signed(PROD_W'(HALF_P));

  assign est_rnd = {1'b0, est} + (EW + 1)'(HALF_E);
  assign res     = est_rnd[EW:FRAC_E];
  assign res_sat = res[SAMPLE_BITS] ? '1 : res[SAMPLE_BITS-1:0];

  assign div_start = (ctrl.op == OP_DIV_START);

  skf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pp_r),
    .divisor  (denom_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign status.jump     = jump_r;
  assign status.div_busy = div_busy;
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_noise <= QN_RESET;
      r_noise <= RN_RESET;
      thr     <= THR_RESET;
      weight  <= BW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROCESS_NOISE: q_noise <= cfg_data[QN_W-1:0];
        REG_MEAS_NOISE:    r_noise <= cfg_data[RN_W-1:0];
        REG_JUMP_THR:      thr     <= cfg_data[THR_W-1:0];
        REG_BLEND_W:       weight  <= cfg_data[BW_W-1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est       <= '0;
      cov       <= COV_RESET;
      out_valid <= 1'b0;
    end else begin
      // a new result may replace one taken at the same edge
      if (ctrl.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.op)
        OP_LOAD: s_r <= SAMPLE_BITS'(item.sample);
        OP_PREP: begin
          jump_r <= CMP_W'(distance) >= CMP_W'({thr, {FRAC_E{1'b0}}});
          diff_r <= $signed({1'b0, z}) - $signed({1'b0, est});
          pp_r   <= pp_sum[COV_W] ? '1 : pp_sum[COV_W-1:0];
          pred_r <= est;
        end
        OP_BLEND_MUL, OP_CORR_MUL, OP_COV_MUL: prod_r <= mul_a * mul_b;
        OP_BLEND_ADD: pred_r  <= pred_sum[EW-1:0];
        OP_DENOM:     denom_r <= CMP_W'(pp_r) + CMP_W'(r_noise);
        OP_MAG: begin
          if (denom_r == '0) begin
            gain_r <= '0;
          end else begin
            gain_r <= (quotient > ONE_P) ? ONE_P : quotient;
          end
          neg_r <= z < pred_r;
          mag_r <= (z >= pred_r) ? z - pred_r : pred_r - z;
        end
        OP_CORR_ADD: est <= est_clamped;
        OP_COV_ADD:  cov <= cov_full[FRAC_P +: COV_W];
        OP_EMIT: begin
          out_item.filtered  <= SAMPLE_W'(res_sat);
          out_item.jump_seen <= jump_r;
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/scalar_kalman_sample_filter.sv
// channel   dir  payload                          request taken when
// samples   in   sample[11:0]                     valid && ready
// results   out  filtered[11:0], jump_seen        valid && ready
// cfg       in   cfg_index, cfg_data[31:0]        cfg_we
//
// a new request is taken only at the idle step, after the last one's program;
// the blend prediction is applied only on a jump. the serial gain divider
// dominates, the rest is one step per microcode word on one shared multiplier.
// reset loads the register defaults, estimate 0, covariance 1.0, empty output.
// a result not taken holds the program at its emit step; samples.ready is high
// only at the idle step, while a finished result may still wait at the output.
module scalar_kalman_sample_filter import skf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  skf_stream_if.sink            samples,
  skf_stream_if.source          results
);

  ctrl_t     ctrl;
  status_t   status;
  out_item_t out_item;
  in_item_t  in_item;

  assign in_item       = samples.data;
  assign samples.ready = ctrl.idle;
  assign results.data  = out_item;

  skf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  skf_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .item      (in_item),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .out_item  (out_item),
    .status    (status)
  );

endmodule
